// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL. Both macros sample on the rising edge of clk
// and are switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold on every clock edge.
`define CHK_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant check failed");

// A condition that must hold in the cycle after its trigger.
`define CHK_NEXT(label, trig, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/ile_pkg.sv =====
package ile_pkg;

  localparam int ACT_W  = 2;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;
  localparam int SUM_W  = 38;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_SEARCH = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // What every cell of the chain does on the coming clock edge.
  typedef enum logic [2:0] {
    CM_HOLD   = 3'd0,
    CM_APPEND = 3'd1,
    CM_INSERT = 3'd2,
    CM_DELETE = 3'd3,
    CM_ROTATE = 3'd4
  } cell_mode_t;

  typedef struct packed {
    logic                    found;
    logic [POS_W-1:0]        found_position;
    logic signed [VAL_W-1:0] largest;
    logic signed [VAL_W-1:0] smallest;
    logic signed [SUM_W-1:0] total;
  } scan_res_t;

endpackage

// ===== hw/rtl/indexed_list_engine.sv =====
// Ordered list of up to DEPTH signed 32-bit entries held in a chain of cells.
// Each input transaction appends, inserts at a position, deletes at a
// position or searches for a key, and yields one result transaction with the
// status, the count, the search outcome and the maximum, minimum and sum of
// the entries. The count is the number of entries held after the operation.
// A transaction first shifts the chain; the occupied cells then rotate past
// the single reduction unit at the head of the chain, one entry per cycle,
// and the result register is loaded once it is free (a stall on the output
// holds it). The input is stalled meanwhile; a finished result waits in its
// own register, so the next transaction may start before it is taken.
`include "assert_macros.svh"

module indexed_list_engine #(
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ile_pkg::ACT_W-1:0]        action,
  input  logic [ile_pkg::POS_W-1:0]        position,
  input  logic signed [ile_pkg::VAL_W-1:0] value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ile_pkg::STAT_W-1:0]       status,
  output logic [ile_pkg::CNT_W-1:0]        count,
  output logic                             found,
  output logic [ile_pkg::POS_W-1:0]        found_position,
  output logic signed [ile_pkg::VAL_W-1:0] largest,
  output logic signed [ile_pkg::VAL_W-1:0] smallest,
  output logic signed [ile_pkg::SUM_W-1:0] total
);
  import ile_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);
  localparam int PW = (NW > POS_W) ? NW : POS_W;
  localparam int XW = (NW > CNT_W) ? NW : CNT_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                  state;
  logic [NW-1:0]           used;
  logic [NW-1:0]           used_next;
  logic [NW-1:0]           k;
  logic signed [VAL_W-1:0] key;
  logic                    search;
  status_t                 op_status;
  status_t                 acc_status;
  cell_mode_t              acc_mode;
  cell_mode_t              cell_mode;
  logic                    in_fire;
  logic                    scan_done;
  logic                    out_load;
  logic                    is_full;
  logic                    is_empty;
  logic [PW-1:0]           pos_w;
  logic [PW-1:0]           used_w;
  logic [NW-1:0]           pos_n;
  scan_res_t               scan_res;
  logic signed [VAL_W-1:0] ent [DEPTH];

  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign scan_done = (k == used);
  assign out_load  = (state == S_SCAN) && scan_done && (!out_valid || !out_stall);

  assign is_full  = (used == NW'(DEPTH));
  assign is_empty = (used == '0);
  assign pos_w    = PW'(position);
  assign used_w   = PW'(used);
  // Only used by the cells once the position has been checked against the count.
  assign pos_n    = NW'(pos_w);

  always_comb begin
    acc_status = ST_OK;
    acc_mode   = CM_HOLD;
    used_next  = used;
    unique case (action_t'(action))
      ACT_APPEND: begin
        if (is_full) begin
          acc_status = ST_FULL;
        end else begin
          acc_mode  = CM_APPEND;
          used_next = used + NW'(1);
        end
      end
      ACT_INSERT: begin
        if (is_full) begin
          acc_status = ST_FULL;
        end else if (pos_w > used_w) begin
          acc_status = ST_RANGE;
        end else begin
          acc_mode  = CM_INSERT;
          used_next = used + NW'(1);
        end
      end
      ACT_DELETE: begin
        if (is_empty) begin
          acc_status = ST_EMPTY;
        end else if (pos_w >= used_w) begin
          acc_status = ST_RANGE;
        end else begin
          acc_mode  = CM_DELETE;
          used_next = used - NW'(1);
        end
      end
      ACT_SEARCH: begin
        if (is_empty) acc_status = ST_EMPTY;
      end
      default: begin
        acc_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    if (in_fire) begin
      cell_mode = acc_mode;
    end else if (state == S_SCAN && !scan_done) begin
      cell_mode = CM_ROTATE;
    end else begin
      cell_mode = CM_HOLD;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_in;
    logic signed [VAL_W-1:0] right_in;

    if (i == 0) begin : g_head
      assign left_in = value;
    end else begin : g_body
      assign left_in = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_in = ent[i];
    end else begin : g_inner
      assign right_in = ent[i+1];
    end

    ile_cell #(.DEPTH(DEPTH)) u_cell (
      .clk    (clk),
      .mode   (cell_mode),
      .idx    (IW'(i)),
      .pos_n  (pos_n),
      .used_n (used),
      .value  (value),
      .left   (left_in),
      .right  (right_in),
      .first  (ent[0]),
      .entry  (ent[i])
    );
  end

  ile_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (in_fire),
    .step      ((state == S_SCAN) && !scan_done),
    .elem      (ent[0]),
    .key       (key),
    .search_en (search),
    .res       (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            used  <= used_next;
            k     <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!scan_done) begin
            k <= k + NW'(1);
          end else if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      key       <= value;
      search    <= (action_t'(action) == ACT_SEARCH);
      op_status <= acc_status;
    end
    if (out_load) begin
      status         <= op_status;
      count          <= CNT_W'(XW'(used));
      found          <= scan_res.found;
      found_position <= scan_res.found_position;
      largest        <= scan_res.largest;
      smallest       <= scan_res.smallest;
      total          <= scan_res.total;
    end
  end

  `CHK_ALWAYS(a_used_in_range, used <= NW'(DEPTH))
  `CHK_ALWAYS(a_scan_in_range, k <= used)
  `CHK_NEXT(a_flagged_keeps_count, in_fire && acc_status != ST_OK, $stable(used))

endmodule

// ===== hw/rtl/ile_cell.sv =====
module ile_cell #(
  parameter int DEPTH = 64,
  localparam int IW = $clog2(DEPTH),
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  logic                            clk,
  input  ile_pkg::cell_mode_t             mode,
  input  logic [IW-1:0]                   idx,
  input  logic [NW-1:0]                   pos_n,
  input  logic [NW-1:0]                   used_n,
  input  logic signed [ile_pkg::VAL_W-1:0] value,
  input  logic signed [ile_pkg::VAL_W-1:0] left,
  input  logic signed [ile_pkg::VAL_W-1:0] right,
  input  logic signed [ile_pkg::VAL_W-1:0] first,
  output logic signed [ile_pkg::VAL_W-1:0] entry
);
  import ile_pkg::*;

  logic [NW-1:0]           idx_n;
  logic [NW-1:0]           idx_p1;
  logic signed [VAL_W-1:0] entry_next;

  assign idx_n  = NW'(idx);
  assign idx_p1 = idx_n + NW'(1);

  always_comb begin
    entry_next = entry;
    unique case (mode)
      CM_HOLD: begin
        entry_next = entry;
      end
      CM_APPEND: begin
        if (idx_n == used_n) entry_next = value;
      end
      CM_INSERT: begin
        if (idx_n == pos_n) begin
          entry_next = value;
        end else if (idx_n > pos_n && idx_n <= used_n) begin
          entry_next = left;
        end
      end
      CM_DELETE: begin
        if (idx_n >= pos_n && idx_p1 < used_n) entry_next = right;
      end
      CM_ROTATE: begin
        // The occupied part of the chain turns left by one; the head wraps
        // round to the last occupied cell.
        if (idx_p1 < used_n) begin
          entry_next = right;
        end else if (idx_p1 == used_n) begin
          entry_next = first;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== hw/rtl/ile_scan.sv =====
module ile_scan (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             step,
  input  logic signed [ile_pkg::VAL_W-1:0] elem,
  input  logic signed [ile_pkg::VAL_W-1:0] key,
  input  logic                             search_en,
  output ile_pkg::scan_res_t               res
);
  import ile_pkg::*;

  logic                    first_elem;
  logic [POS_W-1:0]        elem_pos;
  logic signed [SUM_W-1:0] elem_wide;

  assign elem_wide = {{(SUM_W - VAL_W){elem[VAL_W-1]}}, elem};

  always_ff @(posedge clk) begin
    if (rst) begin
      first_elem <= 1'b1;
      res.found  <= 1'b0;
    end else if (start) begin
      first_elem         <= 1'b1;
      res.found          <= 1'b0;
      elem_pos           <= '0;
      res.found_position <= '0;
      res.largest        <= '0;
      res.smallest       <= '0;
      res.total          <= '0;
    end else if (step) begin
      first_elem <= 1'b0;
      elem_pos   <= elem_pos + POS_W'(1);
      res.total  <= res.total + elem_wide;
      if (first_elem || elem > res.largest) res.largest <= elem;
      if (first_elem || elem < res.smallest) res.smallest <= elem;
      // Only the lowest matching position is kept.
      if (search_en && !res.found && elem == key) begin
        res.found          <= 1'b1;
        res.found_position <= elem_pos;
      end
    end
  end

endmodule
